@@ hdl/dual_led_color_fade_blink_core_macros.svh @@
// Assertion macros for the LED fade/blink core.
`ifndef DUAL_LED_COLOR_FADE_BLINK_CORE_MACROS_SVH
`define DUAL_LED_COLOR_FADE_BLINK_CORE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define DLC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define DLC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ hdl/dlcfb_pkg.sv @@
// Shared constants, types and a helper function of the LED fade/blink core.
`timescale 1ns / 1ps
package dlcfb_pkg;
    localparam int FRACTION_BITS = 16;
    localparam int FW = FRACTION_BITS + 1;
    localparam int TW = 31;
    localparam int HW = 16;
    localparam int DIV_STEPS = 32;

    localparam logic [2:0] REG_MODE    = 3'd0;
    localparam logic [2:0] REG_L0_LOW  = 3'd1;
    localparam logic [2:0] REG_L0_HIGH = 3'd2;
    localparam logic [2:0] REG_L1_LOW  = 3'd3;
    localparam logic [2:0] REG_L1_HIGH = 3'd4;
    localparam logic [2:0] REG_L0_TIME = 3'd5;
    localparam logic [2:0] REG_L1_TIME = 3'd6;

    localparam logic [1:0] MODE_INDEP  = 2'd0;
    localparam logic [1:0] MODE_MIRROR = 2'd1;
    localparam logic [1:0] MODE_INVERT = 2'd2;

    typedef struct packed {
        logic [8:0] hue;
        logic [6:0] sat;
        logic [6:0] val;
        logic       lit;
    } t_led;

    // Interpolate one channel: floor(lo + (hi-lo)*f / 2^FB).
    function automatic logic [8:0] lerp9(input logic [8:0] lo, input logic [8:0] hi,
                                         input logic [FW-1:0] f);
        logic signed [FW+11:0] acc;
        begin
            acc = $signed({{(FW+3){1'b0}}, lo}) <<< FRACTION_BITS;
            acc = acc + ($signed({3'b000, hi}) - $signed({3'b000, lo}))
                  * $signed({1'b0, f});
            lerp9 = acc[FRACTION_BITS +: 9];
        end
    endfunction
endpackage

@@ hdl/dlcfb_divmod.sv @@
// Pipelined restoring unit: two quotient/remainder bits per stage.
`timescale 1ns / 1ps
module dlcfb_divmod (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [47:0] i_num,
    input  logic [32:0] i_den,
    output logic [47:0] o_quo,
    output logic [32:0] o_rem
);
    // Each stage resolves 2 bits of a 48-bit dividend; 24 stages.
    localparam int NS = 24;
    logic [47:0] r_q [NS+1];
    logic [33:0] r_r [NS+1];
    logic [32:0] r_d [NS+1];

    always_comb begin
        r_q[0] = i_num;
        r_r[0] = '0;
        r_d[0] = i_den;
    end

    for (genvar s = 0; s < NS; s++) begin : g_st
        logic [47:0] n_q;
        logic [33:0] n_r;
        always_comb begin
            n_q = r_q[s];
            n_r = r_r[s];
            for (int k = 0; k < 2; k++) begin
                n_r = {n_r[32:0], n_q[47]};
                n_q = {n_q[46:0], 1'b0};
                if (n_r >= {1'b0, r_d[s]}) begin
                    n_r = n_r - {1'b0, r_d[s]};
                    n_q[0] = 1'b1;
                end
            end
        end
        logic [47:0] r_qs;
        logic [33:0] r_rs;
        logic [32:0] r_ds;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_qs <= n_q;
                r_rs <= n_r;
                r_ds <= r_d[s];
            end
        end
        always_comb begin
            r_q[s+1] = r_qs;
            r_r[s+1] = r_rs;
            r_d[s+1] = r_ds;
        end
    end

    assign o_quo = r_q[NS];
    assign o_rem = r_r[NS][32:0];

    logic r_unused;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_unused <= 1'b0;
        else          r_unused <= i_valid;
    end
endmodule

@@ hdl/dual_led_color_fade_blink_core.sv @@
// Top level of the dual LED color fade and blink core.
`timescale 1ns / 1ps
`include "dual_led_color_fade_blink_core_macros.svh"
// Channel  | signals                          | beat
// input    | i_valid/o_ready, i_elapsed_ms    | one time stamp
// output   | o_valid/i_ready, o_first_*, o_second_* | two LED colors
// config   | i_cfg_we, i_cfg_idx, i_cfg_data  | one register write
// The path is 24 modulo stages, 24 division stages, then the output register
// that takes the interpolation; one beat can enter every cycle unless stalled.
// The pipeline advances as a whole whenever the output register is free
// or taken; a stall holds every stage, so nothing is dropped or repeated.
// Reset clears the valid bits and loads the configuration registers with defaults.
module dual_led_color_fade_blink_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [30:0] i_elapsed_ms,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [8:0]  o_first_hue,
    output logic [6:0]  o_first_sat,
    output logic [6:0]  o_first_val,
    output logic        o_first_lit,
    output logic [8:0]  o_second_hue,
    output logic [6:0]  o_second_sat,
    output logic [6:0]  o_second_val,
    output logic        o_second_lit,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data
);
    localparam int D1 = 24;   // modulo pipeline depth
    localparam int D2 = 24;   // division pipeline depth
    localparam int DL = D1 + D2;

    logic [1:0]  r_mode;
    logic [22:0] r_c0lo, r_c0hi, r_c1lo, r_c1hi;
    logic [63:0] r_t0, r_t1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= dlcfb_pkg::MODE_INDEP;
            r_c0lo <= 23'd1651300;
            r_c0hi <= 23'd2470500;
            r_c1lo <= 23'd5911140;
            r_c1hi <= 23'd12900;
            r_t0   <= 64'd281479271684505600;
            r_t1   <= 64'd140737917858611200;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dlcfb_pkg::REG_MODE:    r_mode <= i_cfg_data[1:0];
                dlcfb_pkg::REG_L0_LOW:  r_c0lo <= i_cfg_data[22:0];
                dlcfb_pkg::REG_L0_HIGH: r_c0hi <= i_cfg_data[22:0];
                dlcfb_pkg::REG_L1_LOW:  r_c1lo <= i_cfg_data[22:0];
                dlcfb_pkg::REG_L1_HIGH: r_c1hi <= i_cfg_data[22:0];
                dlcfb_pkg::REG_L0_TIME: r_t0   <= i_cfg_data;
                dlcfb_pkg::REG_L1_TIME: r_t1   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Advance the whole pipeline unless the output holds an untaken beat.
    logic w_adv;
    assign w_adv   = !o_valid || i_ready;
    assign o_ready = w_adv;

    // Valid shift line alongside the data stages.
    logic r_v [1:DL];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= DL; k++) r_v[k] <= 1'b0;
        end else if (w_adv) begin
            r_v[1] <= i_valid;
            for (int k = 2; k <= DL; k++) r_v[k] <= r_v[k-1];
        end
    end

    // Stage A: four modulo operations on the input time.
    logic [15:0] w_h0, w_h1;
    logic [32:0] w_w0, w_w1;
    assign w_h0 = r_t0[63:48];
    assign w_h1 = r_t1[63:48];
    assign w_w0 = {17'd0, r_t0[47:32]} + {17'd0, r_t0[31:16]};
    assign w_w1 = {17'd0, r_t1[47:32]} + {17'd0, r_t1[31:16]};

    logic [47:0] w_qa0, w_qa1, w_qb0, w_qb1;
    logic [32:0] w_ma0, w_ma1, w_mb0, w_mb1;
    logic [32:0] w_da0, w_da1, w_db0, w_db1;
    assign w_da0 = (w_h0 == '0) ? 33'd1 : {16'd0, w_h0, 1'b0};
    assign w_da1 = (w_h1 == '0) ? 33'd1 : {16'd0, w_h1, 1'b0};
    assign w_db0 = (w_w0 == '0) ? 33'd1 : w_w0;
    assign w_db1 = (w_w1 == '0) ? 33'd1 : w_w1;

    dlcfb_divmod u_ma0 (.i_clk, .i_rst_n, .i_en(w_adv), .i_valid,
        .i_num({17'd0, i_elapsed_ms}), .i_den(w_da0), .o_quo(w_qa0), .o_rem(w_ma0));
    dlcfb_divmod u_ma1 (.i_clk, .i_rst_n, .i_en(w_adv), .i_valid,
        .i_num({17'd0, i_elapsed_ms}), .i_den(w_da1), .o_quo(w_qa1), .o_rem(w_ma1));
    dlcfb_divmod u_mb0 (.i_clk, .i_rst_n, .i_en(w_adv), .i_valid,
        .i_num({16'd0, 1'b0, i_elapsed_ms} + {32'd0, r_t0[15:0]}),
        .i_den(w_db0), .o_quo(w_qb0), .o_rem(w_mb0));
    dlcfb_divmod u_mb1 (.i_clk, .i_rst_n, .i_en(w_adv), .i_valid,
        .i_num({16'd0, 1'b0, i_elapsed_ms} + {32'd0, r_t1[15:0]}),
        .i_den(w_db1), .o_quo(w_qb1), .o_rem(w_mb1));

    // Fold the triangle and decide blink on the modulo results.
    logic [16:0] w_n0, w_n1;
    logic        w_lit0, w_lit1;
    always_comb begin
        w_n0 = (w_ma0[16:0] > {1'b0, w_h0}) ? ({w_h0, 1'b0} - w_ma0[16:0]) : w_ma0[16:0];
        w_n1 = (w_ma1[16:0] > {1'b0, w_h1}) ? ({w_h1, 1'b0} - w_ma1[16:0]) : w_ma1[16:0];
        w_lit0 = (w_w0 == '0) || (w_mb0 <= {17'd0, r_t0[47:32]});
        w_lit1 = (w_w1 == '0) || (w_mb1 <= {17'd0, r_t1[47:32]});
    end

    // Stage B: fraction division n * 2^FB / half.
    logic [47:0] w_f0q, w_f1q;
    logic [32:0] w_f0r, w_f1r;
    dlcfb_divmod u_f0 (.i_clk, .i_rst_n, .i_en(w_adv), .i_valid(r_v[D1]),
        .i_num(48'({w_n0, {dlcfb_pkg::FRACTION_BITS{1'b0}}})),
        .i_den((w_h0 == '0) ? 33'd1 : {17'd0, w_h0}), .o_quo(w_f0q), .o_rem(w_f0r));
    dlcfb_divmod u_f1 (.i_clk, .i_rst_n, .i_en(w_adv), .i_valid(r_v[D1]),
        .i_num(48'({w_n1, {dlcfb_pkg::FRACTION_BITS{1'b0}}})),
        .i_den((w_h1 == '0) ? 33'd1 : {17'd0, w_h1}), .o_quo(w_f1q), .o_rem(w_f1r));

    // Carry lit flags and zero-half flags across the division stage.
    logic [3:0] r_fl [1:D2];
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_fl[1] <= {w_lit0, w_lit1, w_h0 == '0, w_h1 == '0};
            for (int k = 2; k <= D2; k++) r_fl[k] <= r_fl[k-1];
        end
    end

    logic [dlcfb_pkg::FW-1:0] w_f0, w_f1, w_fl1;
    assign w_f0 = r_fl[D2][1] ? '0 : w_f0q[dlcfb_pkg::FW-1:0];
    assign w_f1 = r_fl[D2][0] ? '0 : w_f1q[dlcfb_pkg::FW-1:0];
    always_comb begin
        case (r_mode)
            dlcfb_pkg::MODE_MIRROR: w_fl1 = w_f0;
            dlcfb_pkg::MODE_INVERT: w_fl1 = (dlcfb_pkg::FW)'(1 << dlcfb_pkg::FRACTION_BITS) - w_f0;
            default:                w_fl1 = w_f1;
        endcase
    end
    logic [22:0] w_lo1, w_hi1;
    assign w_lo1 = (r_mode == dlcfb_pkg::MODE_MIRROR || r_mode == dlcfb_pkg::MODE_INVERT)
                   ? r_c0lo : r_c1lo;
    assign w_hi1 = (r_mode == dlcfb_pkg::MODE_MIRROR || r_mode == dlcfb_pkg::MODE_INVERT)
                   ? r_c0hi : r_c1hi;

    // Final stage: interpolate and blank into the output register.
    dlcfb_pkg::t_led n_l0, n_l1, r_l0, r_l1;
    always_comb begin
        n_l0.hue = dlcfb_pkg::lerp9(r_c0lo[22:14], r_c0hi[22:14], w_f0);
        n_l0.sat = 7'(dlcfb_pkg::lerp9({2'b0, r_c0lo[13:7]}, {2'b0, r_c0hi[13:7]}, w_f0));
        n_l0.val = 7'(dlcfb_pkg::lerp9({2'b0, r_c0lo[6:0]}, {2'b0, r_c0hi[6:0]}, w_f0));
        n_l0.lit = r_fl[D2][3];
        if (!n_l0.lit) n_l0 = '0;
        n_l1.hue = dlcfb_pkg::lerp9(w_lo1[22:14], w_hi1[22:14], w_fl1);
        n_l1.sat = 7'(dlcfb_pkg::lerp9({2'b0, w_lo1[13:7]}, {2'b0, w_hi1[13:7]}, w_fl1));
        n_l1.val = 7'(dlcfb_pkg::lerp9({2'b0, w_lo1[6:0]}, {2'b0, w_hi1[6:0]}, w_fl1));
        n_l1.lit = r_fl[D2][2];
        if (!n_l1.lit) n_l1 = '0;
    end

    logic r_ov;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (w_adv) r_ov <= r_v[DL];
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_l0 <= n_l0;
            r_l1 <= n_l1;
        end
    end
    assign o_valid      = r_ov;
    assign o_first_hue  = r_l0.hue;
    assign o_first_sat  = r_l0.sat;
    assign o_first_val  = r_l0.val;
    assign o_first_lit  = r_l0.lit;
    assign o_second_hue = r_l1.hue;
    assign o_second_sat = r_l1.sat;
    assign o_second_val = r_l1.val;
    assign o_second_lit = r_l1.lit;

    `DLC_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_first_hue), "output beat changed while stalled")
    `DLC_ASSERT_IMP(a_dark0, i_clk, i_rst_n, o_valid && !o_first_lit, o_first_hue == '0 && o_first_val == '0, "led0 not blanked")
    `DLC_ASSERT_IMP(a_dark1, i_clk, i_rst_n, o_valid && !o_second_lit, o_second_hue == '0 && o_second_sat == '0, "led1 not blanked")
    `DLC_ASSERT_IMP(a_ready, i_clk, i_rst_n, !o_valid, o_ready, "ready low with empty output")
endmodule
